/* design/ilt_pkg.sv */
// Shared constants, command and status codes, and beat types for the indexed list table.
`default_nettype none
package ilt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int ENTRY_W  = 7;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] K_READ      = 3'd0;
  localparam logic [2:0] K_INS_HEAD  = 3'd1;
  localparam logic [2:0] K_INS_TAIL  = 3'd2;
  localparam logic [2:0] K_INS_AT    = 3'd3;
  localparam logic [2:0] K_DELETE    = 3'd4;
  localparam logic [2:0] K_POP_FRONT = 3'd5;
  localparam logic [2:0] K_POP_BACK  = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]               kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic [ENTRY_W-1:0]       entry_count;
  } out_t;

endpackage
`default_nettype wire

/* design/indexed_list_table.sv */
// Top level of the indexed list table: command decoder, shift sequencer and entry memory.
//
//   channel | ports                      | beat taken when
//   --------+----------------------------+------------------------------
//   command | start, busy, in_item       | start high while busy is low
//   result  | out_valid, out_item        | every cycle out_valid is high
//
// The result strobe follows the accepting edge: a rejected command goes straight to it, a
// read or a pop back passes through the read-wait state, an insert or a delete moves its
// entries in the shift state first, and a pop front reads the head and then shifts the rest.
// Entries move one per cycle through the memory's read port and write port.
// Reset empties the list at once; entry contents are undefined until written.
// Busy stays high through the strobe cycle, and the receiver cannot stall.
`default_nettype none
module indexed_list_table import ilt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_item
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_DONE   = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pend_r, pend_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [IDX_W-1:0]  ipos_r, ipos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]  src_r, src_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              up_r, up_nxt;
  logic [IDX_W-1:0]  pend_dst_r, pend_dst_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [1:0]        status_r, status_nxt;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd;

  logic [CMP_W-1:0]  pos_w, cnt_w, ins_pos, cnt_less_pos;
  logic [CNT_W-1:0]  cnt_dec;

  always_comb begin
    pos_w        = CMP_W'(in_item.position);
    cnt_w        = CMP_W'(count_r);
    cnt_dec      = count_r - CNT_W'(1);
    cnt_less_pos = cnt_w - pos_w - CMP_W'(1);
    case (in_item.kind)
      K_INS_HEAD: ins_pos = '0;
      K_INS_TAIL: ins_pos = cnt_w;
      default:    ins_pos = pos_w;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pend_nxt     = pend_r;
    kind_nxt     = kind_r;
    ipos_nxt     = ipos_r;
    val_nxt      = val_r;
    src_nxt      = src_r;
    rem_nxt      = rem_r;
    up_nxt       = up_r;
    pend_dst_nxt = pend_dst_r;
    res_nxt      = res_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_wa       = pend_dst_r;
    mem_wd       = rd_data_r;
    mem_re       = 1'b0;
    mem_ra       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt   = in_item.kind;
          val_nxt    = in_item.item_value;
          res_nxt    = '0;
          status_nxt = ST_OK;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
          unique case (in_item.kind) inside
            K_READ: begin
              if (pos_w < cnt_w) begin
                mem_re    = 1'b1;
                mem_ra    = pos_w[IDX_W-1:0];
                state_nxt = S_RDWAIT;
              end else begin
                res_nxt    = '1;
                status_nxt = ST_BAD;
              end
            end
            K_INS_HEAD, K_INS_TAIL, K_INS_AT: begin
              if (in_item.kind == K_INS_AT && pos_w > cnt_w) begin
                status_nxt = ST_BAD;
              end else if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                ipos_nxt  = ins_pos[IDX_W-1:0];
                rem_nxt   = CNT_W'(cnt_w - ins_pos);
                src_nxt   = cnt_dec[IDX_W-1:0];
                up_nxt    = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            K_DELETE: begin
              if (pos_w < cnt_w) begin
                rem_nxt   = CNT_W'(cnt_less_pos);
                src_nxt   = pos_w[IDX_W-1:0] + IDX_W'(1);
                up_nxt    = 1'b0;
                state_nxt = S_SHIFT;
              end else begin
                status_nxt = ST_BAD;
              end
            end
            K_POP_FRONT, K_POP_BACK: begin
              if (count_r != '0) begin
                mem_re    = 1'b1;
                mem_ra    = (in_item.kind == K_POP_BACK) ? cnt_dec[IDX_W-1:0] : '0;
                state_nxt = S_RDWAIT;
              end else begin
                status_nxt = ST_BAD;
              end
            end
            default: begin
              status_nxt = ST_BAD;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_nxt   = rd_data_r;
        state_nxt = S_DONE;
        if (kind_r == K_POP_FRONT) begin
          rem_nxt   = cnt_dec;
          src_nxt   = IDX_W'(1);
          up_nxt    = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else if (kind_r == K_POP_BACK) begin
          count_nxt = cnt_dec;
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (rem_r != '0) begin
          mem_re       = 1'b1;
          mem_ra       = src_r;
          pend_nxt     = 1'b1;
          pend_dst_nxt = up_r ? src_r + IDX_W'(1) : src_r - IDX_W'(1);
          src_nxt      = up_r ? src_r - IDX_W'(1) : src_r + IDX_W'(1);
          rem_nxt      = rem_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (up_r) begin
              mem_we    = 1'b1;
              mem_wa    = ipos_r;
              mem_wd    = val_r;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              count_nxt = cnt_dec;
            end
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    ipos_r     <= ipos_nxt;
    val_r      <= val_nxt;
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    up_r       <= up_nxt;
    pend_dst_r <= pend_dst_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_DONE);
  assign out_item.result_value = res_r;
  assign out_item.status       = status_r;
  assign out_item.entry_count  = ENTRY_W'(count_r);

endmodule
`default_nettype wire
